// File: src/repm_pkg.sv
// Shared types, widths and constants for the RMS envelope peak meter.
`default_nettype none
package repm_pkg;

    localparam int MAX_BLOCK = 256;

    localparam int SAMPLE_W = 16;
    localparam int KIND_W   = 2;
    localparam int MAG_W    = 15;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int COUNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W    = SQ_W + COUNT_W;
    localparam int FRAC_W   = 16;
    localparam int NUM_W    = SUM_W + FRAC_W;
    localparam int RAD_W    = NUM_W + (NUM_W % 2);
    localparam int ROOT_W   = RAD_W / 2;
    localparam int ENV_W    = 23;
    localparam int KEEP_W   = 16;
    localparam int PROD_W   = KEEP_W + 1 + ENV_W;
    localparam int ITER_W   = $clog2(NUM_W + 1);
    localparam int OUT_W    = 56;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;
    localparam logic [ENV_W-1:0] ENV_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_RX   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TX   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    localparam logic REG_ATTACK  = 1'b0;
    localparam logic REG_RELEASE = 1'b1;

    localparam logic [KEEP_W-1:0] ATTACK_RESET  = 16'd26214;
    localparam logic [KEEP_W-1:0] RELEASE_RESET = 16'd61604;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              last;
        logic [MAG_W-1:0]  mag;
        logic [SQ_W-1:0]   sq;
    } op_t;

    typedef struct packed {
        logic [KEEP_W-1:0] attack_keep;
        logic [KEEP_W-1:0] release_keep;
    } cfg_t;

    typedef struct packed {
        logic [ENV_W-1:0] envelope_level;
        logic [MAG_W-1:0] peak_receive;
        logic [MAG_W-1:0] peak_transmit;
        logic             from_read;
    } result_t;

endpackage
`default_nettype wire

// File: src/rms_envelope_peak_meter.sv
// Top level of the RMS envelope peak meter: front end, queue, back end and registers.
//
//  channel   dir  handshake           contents
//  s_        in   s_tvalid/s_tready   tdata sample, tuser kind, tlast end of block
//  m_        out  m_tvalid/m_tready   tdata envelope and peaks, tuser from_read
//  apb       in   psel/penable        attack_keep at 0x0, release_keep at 0x4
//
// Receive, transmit and read beats are each taken by the back end while it is idle; a four-entry
// queue lets the input keep flowing while the back end is busy.
// A receive beat with tlast then runs the divider and square root, one bit a cycle each,
// and the multiply, envelope update and emit steps of the back end.
// Reset is synchronous, active low, and clears sum, count, envelope and peaks.
// A stalled result holds in the output register; a read waits only for that slot.
`default_nettype none
module rms_envelope_peak_meter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,  // [15:0] sample
    input  wire logic [1:0]                    s_tuser,  // [1:0] kind
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [repm_pkg::OUT_W-1:0]         m_tdata,  // [22:0] envelope_level,
                                                         // [37:23] peak_receive,
                                                         // [52:38] peak_transmit
    output logic [0:0]                         m_tuser,  // [0] from_read
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [repm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [repm_pkg::DATA_W-1:0]   pwdata,
    output logic      [repm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    repm_pkg::cfg_t    cfg;
    repm_pkg::op_t     push_entry;
    repm_pkg::op_t     head_entry;
    repm_pkg::result_t result;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;

    repm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    repm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    repm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .entry_in  (push_entry),
        .pop       (q_pop),
        .entry_out (head_entry),
        .empty     (q_empty),
        .full      (q_full)
    );

    repm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .op       (head_entry),
        .op_valid (!q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = {{(repm_pkg::OUT_W - repm_pkg::ENV_W - 2*repm_pkg::MAG_W){1'b0}},
                      result.peak_transmit, result.peak_receive, result.envelope_level};
    assign m_tuser = result.from_read;

endmodule
`default_nettype wire

// File: src/repm_regs.sv
// APB register file holding the attack and release weights.
`default_nettype none
module repm_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [repm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [repm_pkg::DATA_W-1:0]  pwdata,
    output logic      [repm_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output repm_pkg::cfg_t                    cfg
);

    logic [repm_pkg::KEEP_W-1:0] attack_reg, attack_next;
    logic [repm_pkg::KEEP_W-1:0] release_reg, release_next;
    logic                        wr_en;
    logic                        sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = paddr[2];

    always_comb begin
        attack_next  = attack_reg;
        release_next = release_reg;
        if (wr_en) begin
            case (sel)
                repm_pkg::REG_ATTACK:  attack_next  = pwdata[repm_pkg::KEEP_W-1:0];
                repm_pkg::REG_RELEASE: release_next = pwdata[repm_pkg::KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            repm_pkg::REG_ATTACK:
                prdata = {{(repm_pkg::DATA_W-repm_pkg::KEEP_W){1'b0}}, attack_reg};
            repm_pkg::REG_RELEASE:
                prdata = {{(repm_pkg::DATA_W-repm_pkg::KEEP_W){1'b0}}, release_reg};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= repm_pkg::ATTACK_RESET;
            release_reg <= repm_pkg::RELEASE_RESET;
        end else begin
            attack_reg  <= attack_next;
            release_reg <= release_next;
        end
    end

    assign cfg.attack_keep  = attack_reg;
    assign cfg.release_keep = release_reg;

endmodule
`default_nettype wire

// File: src/repm_front.sv
// Input side: accepts beats, takes the magnitude and square, drops unused kinds.
`default_nettype none
module repm_front (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [repm_pkg::SAMPLE_W-1:0]  s_tdata,
    input  wire logic [repm_pkg::KIND_W-1:0]    s_tuser,
    input  wire logic                           s_tlast,
    input  wire logic                           q_full,
    output logic                                q_push,
    output repm_pkg::op_t                       q_entry
);

    logic [repm_pkg::SAMPLE_W-1:0] neg;
    logic [repm_pkg::MAG_W-1:0]    mag;
    logic                          known;

    assign s_tready = !q_full;

    // -32768 negates to itself; saturate it
    assign neg = repm_pkg::SAMPLE_W'(0) - s_tdata;
    always_comb begin
        if (s_tdata[repm_pkg::SAMPLE_W-1]) begin
            mag = neg[repm_pkg::SAMPLE_W-1] ? repm_pkg::MAG_MAX : neg[repm_pkg::MAG_W-1:0];
        end else begin
            mag = s_tdata[repm_pkg::MAG_W-1:0];
        end
    end

    assign known = (s_tuser == repm_pkg::KIND_RX) || (s_tuser == repm_pkg::KIND_TX)
                || (s_tuser == repm_pkg::KIND_READ);

    assign q_push        = s_tvalid && !q_full && known;
    assign q_entry.kind  = s_tuser;
    assign q_entry.last  = s_tlast;
    assign q_entry.mag   = mag;
    assign q_entry.sq    = repm_pkg::SQ_W'(mag) * repm_pkg::SQ_W'(mag);

endmodule
`default_nettype wire

// File: src/repm_queue.sv
// Short register queue between the front and back ends.
`default_nettype none
module repm_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  repm_pkg::op_t      entry_in,
    input  wire logic          pop,
    output repm_pkg::op_t      entry_out,
    output logic               empty,
    output logic               full
);

    repm_pkg::op_t             mem_reg [repm_pkg::QUEUE_DEPTH];
    logic [repm_pkg::QPTR_W:0] wr_ptr_reg, wr_ptr_next;
    logic [repm_pkg::QPTR_W:0] rd_ptr_reg, rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[repm_pkg::QPTR_W-1:0] == rd_ptr_reg[repm_pkg::QPTR_W-1:0])
                && (wr_ptr_reg[repm_pkg::QPTR_W] != rd_ptr_reg[repm_pkg::QPTR_W]);

    assign entry_out   = mem_reg[rd_ptr_reg[repm_pkg::QPTR_W-1:0]];
    assign wr_ptr_next = wr_ptr_reg + (repm_pkg::QPTR_W+1)'(push && !full);
    assign rd_ptr_next = rd_ptr_reg + (repm_pkg::QPTR_W+1)'(pop && !empty);

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg[repm_pkg::QPTR_W-1:0]] <= entry_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule
`default_nettype wire

// File: src/repm_back.sv
// Back end: peak holds, square sum, serial divide and root, envelope update, result register.
`default_nettype none
module repm_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  repm_pkg::cfg_t     cfg,
    input  repm_pkg::op_t      op,
    input  wire logic          op_valid,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output repm_pkg::result_t  result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_MULA = 3'd3;
    localparam logic [2:0] ST_MULB = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    localparam logic [repm_pkg::KEEP_W:0]   KEEP_ONE =
        (repm_pkg::KEEP_W+1)'(1) << repm_pkg::KEEP_W;
    localparam logic [repm_pkg::PROD_W:0]   ROUND    =
        (repm_pkg::PROD_W+1)'(1) << (repm_pkg::KEEP_W - 1);

    logic [2:0]                     state_reg, state_next;
    logic [repm_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [repm_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [repm_pkg::ENV_W-1:0]     env_reg, env_next;
    logic [repm_pkg::MAG_W-1:0]     rx_peak_reg, rx_peak_next;
    logic [repm_pkg::MAG_W-1:0]     tx_peak_reg, tx_peak_next;
    logic [repm_pkg::NUM_W-1:0]     num_reg, num_next;
    logic [repm_pkg::COUNT_W-1:0]   rem_reg, rem_next;
    logic [repm_pkg::COUNT_W-1:0]   div_reg, div_next;
    logic [repm_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic [repm_pkg::RAD_W-1:0]     rad_reg, rad_next;
    logic [repm_pkg::ROOT_W-1:0]    root_reg, root_next;
    logic [repm_pkg::ROOT_W:0]      srem_reg, srem_next;
    logic [repm_pkg::ENV_W-1:0]     rms_reg, rms_next;
    logic [repm_pkg::KEEP_W-1:0]    keep_reg, keep_next;
    logic [repm_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [repm_pkg::PROD_W-1:0]    acc_reg, acc_next;
    logic                           out_valid_reg, out_valid_next;
    repm_pkg::result_t              out_reg, out_next;

    logic                           out_free;
    logic                           in_block;
    logic [repm_pkg::SUM_W-1:0]     sum_add;
    logic [repm_pkg::COUNT_W-1:0]   cnt_add;
    logic [repm_pkg::MAG_W-1:0]     rx_max;
    logic [repm_pkg::MAG_W-1:0]     tx_max;
    logic [repm_pkg::COUNT_W:0]     rem_sh;
    logic [repm_pkg::COUNT_W:0]     rem_diff;
    logic                           q_bit;
    logic [repm_pkg::NUM_W-1:0]     num_shift;
    logic [repm_pkg::ROOT_W+2:0]    rem2;
    logic [repm_pkg::ROOT_W+2:0]    trial;
    logic [repm_pkg::ROOT_W+2:0]    sq_diff;
    logic                           take;
    logic [repm_pkg::ROOT_W-1:0]    root_shift;
    logic [repm_pkg::ENV_W-1:0]     rms_sat;
    logic [repm_pkg::KEEP_W:0]      weight;
    logic [repm_pkg::KEEP_W+repm_pkg::ENV_W-1:0] prod_a;
    logic [repm_pkg::PROD_W-1:0]    prod_b;
    logic [repm_pkg::PROD_W:0]      total;
    logic [repm_pkg::PROD_W-repm_pkg::KEEP_W:0] env_wide;

    assign out_free = !out_valid_reg || m_tready;
    assign in_block = count_reg < repm_pkg::COUNT_W'(repm_pkg::MAX_BLOCK);
    assign sum_add  = sum_reg + (in_block ? repm_pkg::SUM_W'(op.sq) : '0);
    assign cnt_add  = count_reg + repm_pkg::COUNT_W'(in_block);
    assign rx_max   = (op.mag > rx_peak_reg) ? op.mag : rx_peak_reg;
    assign tx_max   = (op.mag > tx_peak_reg) ? op.mag : tx_peak_reg;

    // restoring divide, one quotient bit a cycle
    assign rem_sh    = {rem_reg, num_reg[repm_pkg::NUM_W-1]};
    assign q_bit     = rem_sh >= {1'b0, div_reg};
    assign rem_diff  = rem_sh - {1'b0, div_reg};
    assign num_shift = {num_reg[repm_pkg::NUM_W-2:0], q_bit};

    // digit-by-digit square root, one root bit a cycle
    assign rem2       = {srem_reg, rad_reg[repm_pkg::RAD_W-1 -: 2]};
    assign trial      = {1'b0, root_reg, 2'b01};
    assign take       = rem2 >= trial;
    assign sq_diff    = rem2 - trial;
    assign root_shift = {root_reg[repm_pkg::ROOT_W-2:0], take};
    assign rms_sat    = (root_shift > repm_pkg::ROOT_W'(repm_pkg::ENV_MAX))
                      ? repm_pkg::ENV_MAX : root_shift[repm_pkg::ENV_W-1:0];

    assign weight   = KEEP_ONE - {1'b0, keep_reg};
    assign prod_a   = (repm_pkg::KEEP_W+repm_pkg::ENV_W)'(keep_reg)
                    * (repm_pkg::KEEP_W+repm_pkg::ENV_W)'(env_reg);
    assign prod_b   = repm_pkg::PROD_W'(weight) * repm_pkg::PROD_W'(rms_reg);
    assign total    = {1'b0, acc_reg} + {1'b0, prod_reg} + ROUND;
    assign env_wide = total[repm_pkg::PROD_W:repm_pkg::KEEP_W];

    always_comb begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        env_next       = env_reg;
        rx_peak_next   = rx_peak_reg;
        tx_peak_next   = tx_peak_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        iter_next      = iter_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        rms_next       = rms_reg;
        keep_next      = keep_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        pop            = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (op_valid) begin
                    case (op.kind)
                        repm_pkg::KIND_RX: begin
                            pop          = 1'b1;
                            rx_peak_next = rx_max;
                            if (op.last) begin
                                sum_next   = '0;
                                count_next = '0;
                                num_next   = {sum_add, {repm_pkg::FRAC_W{1'b0}}};
                                div_next   = cnt_add;
                                rem_next   = '0;
                                iter_next  = repm_pkg::ITER_W'(repm_pkg::NUM_W);
                                state_next = ST_DIV;
                            end else begin
                                sum_next   = sum_add;
                                count_next = cnt_add;
                            end
                        end
                        repm_pkg::KIND_TX: begin
                            pop          = 1'b1;
                            tx_peak_next = tx_max;
                        end
                        repm_pkg::KIND_READ: begin
                            if (out_free) begin
                                pop                     = 1'b1;
                                out_valid_next          = 1'b1;
                                out_next.envelope_level = env_reg;
                                out_next.peak_receive   = rx_peak_reg;
                                out_next.peak_transmit  = tx_peak_reg;
                                out_next.from_read      = 1'b1;
                                rx_peak_next            = '0;
                                tx_peak_next            = '0;
                            end
                        end
                        default: pop = 1'b1;
                    endcase
                end
            end
            ST_DIV: begin
                rem_next  = q_bit ? rem_diff[repm_pkg::COUNT_W-1:0]
                                  : rem_sh[repm_pkg::COUNT_W-1:0];
                num_next  = num_shift;
                iter_next = iter_reg - repm_pkg::ITER_W'(1);
                if (iter_reg == repm_pkg::ITER_W'(1)) begin
                    rad_next   = repm_pkg::RAD_W'(num_shift);
                    root_next  = '0;
                    srem_next  = '0;
                    iter_next  = repm_pkg::ITER_W'(repm_pkg::ROOT_W);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                srem_next = take ? sq_diff[repm_pkg::ROOT_W:0] : rem2[repm_pkg::ROOT_W:0];
                root_next = root_shift;
                rad_next  = rad_reg << 2;
                iter_next = iter_reg - repm_pkg::ITER_W'(1);
                if (iter_reg == repm_pkg::ITER_W'(1)) begin
                    rms_next   = rms_sat;
                    keep_next  = (rms_sat > env_reg) ? cfg.attack_keep : cfg.release_keep;
                    state_next = ST_MULA;
                end
            end
            ST_MULA: begin
                prod_next  = repm_pkg::PROD_W'(prod_a);
                state_next = ST_MULB;
            end
            ST_MULB: begin
                acc_next   = prod_reg;
                prod_next  = prod_b;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                env_next   = (env_wide >
                              (repm_pkg::PROD_W-repm_pkg::KEEP_W+1)'(repm_pkg::ENV_MAX))
                           ? repm_pkg::ENV_MAX : env_wide[repm_pkg::ENV_W-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next          = 1'b1;
                    out_next.envelope_level = env_reg;
                    out_next.peak_receive   = rx_peak_reg;
                    out_next.peak_transmit  = tx_peak_reg;
                    out_next.from_read      = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            env_reg       <= '0;
            rx_peak_reg   <= '0;
            tx_peak_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            env_reg       <= env_next;
            rx_peak_reg   <= rx_peak_next;
            tx_peak_reg   <= tx_peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        iter_reg <= iter_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
        rms_reg  <= rms_next;
        keep_reg <= keep_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

endmodule
`default_nettype wire

// File: verif/repm_checker.sv
// Scoreboard for the RMS envelope peak meter: predicts and checks m_ beats.
module repm_checker
    import repm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] sample
    input  logic [1:0]           s_tuser,   // [1:0] kind
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,   // [22:0] envelope, [37:23] rx peak, [52:38] tx peak
    input  logic [0:0]           m_tuser,   // [0] from_read
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    input  logic                 pready,
    output int                   fail_count,
    output int                   pending,
    output int                   results_checked,
    output int                   reads_checked
);

    localparam logic [ADDR_W-1:0] ATTACK_ADDR  = {REG_ATTACK, 2'b00};
    localparam logic [ADDR_W-1:0] RELEASE_ADDR = {REG_RELEASE, 2'b00};

    logic [KEEP_W-1:0]  attack_w;
    logic [KEEP_W-1:0]  release_w;
    logic [SUM_W-1:0]   sq_acc;
    logic [COUNT_W-1:0] blk_len;
    logic [ENV_W-1:0]   env_q;
    logic [MAG_W-1:0]   rx_peak;
    logic [MAG_W-1:0]   tx_peak;
    result_t            due_levels[$];

    // -32768 has no positive twin in 16 bits, so it clips to full scale
    function automatic logic [MAG_W-1:0] sample_mag(logic signed [15:0] s);
        if (s == -16'sd32768)
            return MAG_MAX;
        else if (s < 0)
            return MAG_W'(-s);
        else
            return MAG_W'(s);
    endfunction

    // floor(sqrt(x)) built bit by bit from the top; root fits well below 2^29
    function automatic logic [ENV_W-1:0] mean_root(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 28; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return (root > 64'(ENV_MAX)) ? ENV_MAX : root[ENV_W-1:0];
    endfunction

    function automatic logic [ENV_W-1:0] smooth_envelope(logic [ENV_W-1:0] env,
                                                         logic [ENV_W-1:0] rms);
        logic [63:0] keep;
        logic [63:0] acc;
        keep = (rms > env) ? 64'(attack_w) : 64'(release_w);
        acc  = (keep * 64'(env) + (64'd65536 - keep) * 64'(rms) + 64'd32768) >> 16;
        return (acc > 64'(ENV_MAX)) ? ENV_MAX : acc[ENV_W-1:0];
    endfunction

    always @(posedge aclk) begin : track
        logic [MAG_W-1:0] mag;
        logic [63:0]      numer;
        result_t          want;
        result_t          got;
        if (!aresetn) begin
            attack_w  = ATTACK_RESET;
            release_w = RELEASE_RESET;
            sq_acc    = '0;
            blk_len   = '0;
            env_q     = '0;
            rx_peak   = '0;
            tx_peak   = '0;
            due_levels.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ATTACK_ADDR)
                    attack_w = pwdata[KEEP_W-1:0];
                else if (paddr == RELEASE_ADDR)
                    release_w = pwdata[KEEP_W-1:0];
            end

            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    KIND_RX: begin
                        mag = sample_mag(s_tdata);
                        if (mag > rx_peak)
                            rx_peak = mag;
                        // past the cap the beat still feeds the peak but not the mean
                        if (blk_len < MAX_BLOCK) begin
                            sq_acc  = sq_acc + SUM_W'(mag) * SUM_W'(mag);
                            blk_len = blk_len + COUNT_W'(1);
                        end
                        if (s_tlast) begin
                            numer  = 64'(sq_acc) << FRAC_W;
                            env_q  = smooth_envelope(env_q, mean_root(numer / 64'(blk_len)));
                            sq_acc  = '0;
                            blk_len = '0;
                            due_levels.push_back('{env_q, rx_peak, tx_peak, 1'b0});
                        end
                    end
                    KIND_TX: begin
                        mag = sample_mag(s_tdata);
                        if (mag > tx_peak)
                            tx_peak = mag;
                    end
                    KIND_READ: begin
                        due_levels.push_back('{env_q, rx_peak, tx_peak, 1'b1});
                        rx_peak = '0;
                        tx_peak = '0;
                    end
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.envelope_level = m_tdata[22:0];
                got.peak_receive   = m_tdata[37:23];
                got.peak_transmit  = m_tdata[52:38];
                got.from_read      = m_tuser[0];
                if (due_levels.size() == 0) begin
                    $display("%0t: unexpected result beat env=%0d rxpk=%0d txpk=%0d rd=%0b",
                             $time, got.envelope_level, got.peak_receive,
                             got.peak_transmit, got.from_read);
                    fail_count++;
                end else begin
                    want = due_levels.pop_front();
                    results_checked++;
                    if (want.from_read)
                        reads_checked++;
                    if (got !== want) begin
                        $display("%0t: mismatch exp env=%0d rxpk=%0d txpk=%0d rd=%0b",
                                 $time, want.envelope_level, want.peak_receive,
                                 want.peak_transmit, want.from_read);
                        $display("%0t:          got env=%0d rxpk=%0d txpk=%0d rd=%0b",
                                 $time, got.envelope_level, got.peak_receive,
                                 got.peak_transmit, got.from_read);
                        fail_count++;
                    end
                end
            end
        end
        pending = due_levels.size();
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for the RMS envelope peak meter: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
    import repm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;
    localparam logic [ADDR_W-1:0] ATTACK_ADDR  = {REG_ATTACK, 2'b00};
    localparam logic [ADDR_W-1:0] RELEASE_ADDR = {REG_RELEASE, 2'b00};
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 120;
    localparam int PHASES        = 6;
    localparam int PHASE_BEATS   = 130;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;
    logic [1:0]          s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic [0:0]          m_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int fail_count;
    int pending;
    int results_checked;
    int reads_checked;

    int burst_left;
    int hold_count;
    int n_rx, n_tx, n_read, n_spare, n_capped, n_settings;
    logic [KEEP_W-1:0] att_set [PHASES];
    logic [KEEP_W-1:0] rel_set [PHASES];

    rms_envelope_peak_meter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    repm_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .reads_checked   (reads_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Timeout: stimulus or results stalled");
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: own pattern of ready modes, plus long hold-offs on request
    initial begin : sink
        int mode;
        int left;
        int holds_done;
        mode       = 0;
        left       = 0;
        holds_done = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_count != holds_done) begin
                holds_done = hold_count;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(5, 60);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom);
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= left[0];
                endcase
            end
        end
    end

    // one beat on s_; valid stays up across a burst, drops for a random gap after it
    task automatic drive_item(logic [KIND_W-1:0] kind, logic [15:0] smp, logic lst);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        case (kind)
            KIND_RX:   n_rx++;
            KIND_TX:   n_tx++;
            KIND_READ: n_read++;
            default:   n_spare++;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 20);
        end
    endtask

    // sender waits until every result is back, then lets the back end go quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample(int unsigned loudness);
        int unsigned m;
        case (loudness)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 511) - 256);
            2: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h8001;
                endcase
            end
            default: begin
                m = $urandom_range(24000, 32767);
                return $urandom_range(0, 1) ? 16'(m) : 16'(0 - m);
            end
        endcase
    endfunction

    // mostly well-formed blocks of receive beats with tx, reads and unused kinds mixed in
    task automatic play_traffic(int budget, bit capped);
        int sent;
        int len;
        int loud;
        int r;
        sent = 0;
        while (sent < budget) begin
            if (capped) begin
                len    = $urandom_range(257, 262);
                capped = 1'b0;
                n_capped++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(1, 12);
                else if (r < 95)
                    len = $urandom_range(13, 64);
                else
                    len = $urandom_range(65, 200);
            end
            loud = $urandom_range(0, 3);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    drive_item(KIND_TX, pick_sample($urandom_range(0, 3)), 1'($urandom));
                    sent++;
                end else if (r < 16) begin
                    drive_item(KIND_READ, 16'($urandom), 1'($urandom));
                    sent++;
                end else if (r < 19) begin
                    drive_item(KIND_SPARE, 16'($urandom), 1'($urandom));
                end
                drive_item(KIND_RX, pick_sample(loud), i == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_RX;
        s_tlast    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 0;
        hold_count = 0;
        n_rx       = 0;
        n_tx       = 0;
        n_read     = 0;
        n_spare    = 0;
        n_capped   = 0;
        n_settings = 1;

        att_set = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'($urandom), 16'($urandom)};
        rel_set = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'($urandom), 16'($urandom)};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed beats at the reset weights
        drive_item(KIND_READ,  16'h0000, 1'b0);   // read straight out of reset
        drive_item(KIND_RX,    16'h8000, 1'b0);   // most negative sample clips
        drive_item(KIND_RX,    16'h7FFF, 1'b0);
        drive_item(KIND_RX,    16'h0000, 1'b0);
        drive_item(KIND_RX,    16'hFFFF, 1'b1);   // block end, envelope rises
        drive_item(KIND_TX,    16'h8000, 1'b0);
        drive_item(KIND_TX,    16'h7FFF, 1'b0);
        drive_item(KIND_TX,    16'h0001, 1'b1);   // tlast means nothing on tx
        drive_item(KIND_READ,  16'hFFFF, 1'b1);
        drive_item(KIND_READ,  16'h0000, 1'b0);   // peaks already cleared
        drive_item(KIND_SPARE, 16'h8000, 1'b1);   // unused kind, no result
        drive_item(KIND_RX,    16'h0000, 1'b1);   // silent block, envelope falls
        drive_item(KIND_RX,    16'h7FFF, 1'b1);   // one-beat full-scale block
        drive_item(KIND_RX,    16'h8000, 1'b1);
        drive_item(KIND_RX,    16'h0001, 1'b1);
        drive_item(KIND_READ,  16'h0000, 1'b0);
        drive_item(KIND_TX,    16'h5555, 1'b0);
        drive_item(KIND_RX,    16'hAAAA, 1'b1);
        drive_item(KIND_READ,  16'h0000, 1'b0);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            apb_write(ATTACK_ADDR,  DATA_W'(att_set[p]));
            apb_write(RELEASE_ADDR, DATA_W'(rel_set[p]));
            n_settings++;
            if (p == 1 || p == 4)
                hold_count++;
            play_traffic(PHASE_BEATS, p == 2 || p == 5);
            settle();
        end

        $display("Summary: %0d rx, %0d tx, %0d read, %0d unused-kind beats; %0d weight settings",
                 n_rx, n_tx, n_read, n_spare, n_settings);
        $display("         %0d results compared (%0d read answers), %0d blocks past the cap",
                 results_checked, reads_checked, n_capped);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
